[hw/rtl/polygon_bounding_circle_assert.svh]
// assertion macros shared by the polygon bounding circle rtl
// expects signals named clk and rst_n in the including module
`ifndef POLYGON_BOUNDING_CIRCLE_ASSERT_SVH
`define POLYGON_BOUNDING_CIRCLE_ASSERT_SVH

// same-cycle implication
`define PBC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbc assertion failed");

// next-cycle implication
`define PBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbc assertion failed");

`endif

[hw/rtl/pbc_pkg.sv]
// shared constants and control types for the polygon bounding circle block
// no dependencies
`timescale 1ns / 1ps

package pbc_pkg;

    // coordinates carry 4 fraction bits; the arithmetic does not depend on it
    localparam int MAX_VERTS   = 64;
    localparam int COORD_BITS  = 16;

    localparam int CNT_BITS    = $clog2(MAX_VERTS + 1);
    localparam int ADDR_BITS   = $clog2(MAX_VERTS);
    localparam int SUM_BITS    = COORD_BITS + $clog2(MAX_VERTS);
    localparam int ROOT_BITS   = COORD_BITS + 1;
    localparam int DIST_BITS   = 2 * ROOT_BITS;
    localparam int DIV_STEP_BITS = $clog2(SUM_BITS);
    localparam int SQ_STEP_BITS  = $clog2(ROOT_BITS);

    localparam int IN_DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((2 * COORD_BITS + ROOT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic start;
    } unit_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

[hw/rtl/polygon_bounding_circle.sv]
// top level: vertex store, sequencer and shared distance multiplier
// depends on pbc_pkg, pbc_ram, pbc_div, pbc_isqrt and the assertion header
`timescale 1ns / 1ps
//
// channel  | dir | tdata (lsb up)                              | side band
// ---------+-----+---------------------------------------------+---------------------------
// s_axis   | in  | vertex_x[15:0], vertex_y[31:16]             | tlast = last_vertex
// m_axis   | out | center_x[15:0], center_y[31:16],            | tuser = vertex_overflow
//          |     | radius[48:32], zero pad to 56 bits          |
//
// vertices load one per cycle; s_axis_tready stays high while loading
// after the vertex with tlast the block is busy: a start state, two divider
// passes (start, 22 steps and a done strobe), a read, x, y and compare state
// per stored vertex through the single multiplier, a square root pass (start,
// 17 steps, done) and a hand-off state
// a finished result waits in the output register; the block holds in its
// final state until that register frees, then clears and loads again
// rst_n clears the sequencer, sums, count and flags; the store needs no clear
`include "polygon_bounding_circle_assert.svh"

module polygon_bounding_circle
    import pbc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // vertex_x, vertex_y
    input  logic                     s_axis_tlast,   // last_vertex
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // center_x, center_y, radius
    output logic                     m_axis_tuser    // vertex_overflow
);

    // sequencer states
    localparam logic [3:0] S_LOAD      = 4'd0;
    localparam logic [3:0] S_DIVX_GO   = 4'd1;
    localparam logic [3:0] S_DIVX_WAIT = 4'd2;
    localparam logic [3:0] S_DIVY_WAIT = 4'd3;
    localparam logic [3:0] S_RD        = 4'd4;
    localparam logic [3:0] S_DX        = 4'd5;
    localparam logic [3:0] S_DY        = 4'd6;
    localparam logic [3:0] S_CMP       = 4'd7;
    localparam logic [3:0] S_SQ_GO     = 4'd8;
    localparam logic [3:0] S_SQ_WAIT   = 4'd9;
    localparam logic [3:0] S_DONE      = 4'd10;

    localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_VERTS);

    logic [3:0]                   state_reg, state_next;
    logic signed [SUM_BITS-1:0]   sum_x_reg, sum_x_next;
    logic signed [SUM_BITS-1:0]   sum_y_reg, sum_y_next;
    logic [CNT_BITS-1:0]          cnt_reg, cnt_next;
    logic                         ovf_reg, ovf_next;
    logic [CNT_BITS-1:0]          idx_reg, idx_next;
    logic signed [COORD_BITS-1:0] cx_reg, cx_next;
    logic signed [COORD_BITS-1:0] cy_reg, cy_next;
    logic [DIST_BITS-1:0]         dist_reg, dist_next;
    logic [DIST_BITS-1:0]         best_reg, best_next;

    logic                         m_valid_reg, m_valid_next;
    logic signed [COORD_BITS-1:0] out_cx_reg, out_cx_next;
    logic signed [COORD_BITS-1:0] out_cy_reg, out_cy_next;
    logic [ROOT_BITS-1:0]         out_rad_reg, out_rad_next;
    logic                         out_ovf_reg, out_ovf_next;

    logic                         in_accept;
    logic                         store_full;
    logic signed [COORD_BITS-1:0] vx_in, vy_in;

    // store
    logic                         ram_we, ram_re;
    logic [2*COORD_BITS-1:0]      ram_rdata;
    logic signed [COORD_BITS-1:0] st_x, st_y;

    // shared multiplier
    logic signed [COORD_BITS:0]   diff;
    logic [COORD_BITS:0]          mul_op;
    logic [DIST_BITS-1:0]         prod;

    // divider and root
    unit_ctl_t                    div_ctl, sq_ctl;
    unit_sts_t                    div_sts, sq_sts;
    logic signed [SUM_BITS-1:0]   div_in;
    logic signed [SUM_BITS-1:0]   div_q;
    logic [ROOT_BITS-1:0]         sq_root;

    assign vx_in = s_axis_tdata[COORD_BITS-1:0];
    assign vy_in = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

    assign s_axis_tready = (state_reg == S_LOAD);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign store_full    = (cnt_reg == CNT_MAX);

    assign ram_we = in_accept && !store_full;
    assign ram_re = (state_reg == S_RD);

    pbc_ram #(
        .WIDTH(2 * COORD_BITS),
        .DEPTH(MAX_VERTS)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(cnt_reg[ADDR_BITS-1:0]),
        .wdata({vy_in, vx_in}),
        .re   (ram_re),
        .raddr(idx_reg[ADDR_BITS-1:0]),
        .rdata(ram_rdata)
    );

    assign st_x = ram_rdata[COORD_BITS-1:0];
    assign st_y = ram_rdata[2*COORD_BITS-1:COORD_BITS];

    // one operand path: x distance in S_DX, y distance in S_DY
    always_comb
    begin
        if (state_reg == S_DY)
        begin
            diff = (COORD_BITS + 1)'(st_y) - (COORD_BITS + 1)'(cy_reg);
        end
        else
        begin
            diff = (COORD_BITS + 1)'(st_x) - (COORD_BITS + 1)'(cx_reg);
        end
    end

    assign mul_op = diff[COORD_BITS] ? $unsigned(-diff) : $unsigned(diff);
    assign prod   = mul_op * mul_op;

    // divider takes x sum first, y sum right after x finishes
    assign div_ctl.start = (state_reg == S_DIVX_GO)
                        || (state_reg == S_DIVX_WAIT && div_sts.done);
    assign div_in        = (state_reg == S_DIVX_GO) ? sum_x_reg : sum_y_reg;

    pbc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (div_ctl),
        .dividend(div_in),
        .divisor (cnt_reg),
        .sts     (div_sts),
        .quotient(div_q)
    );

    assign sq_ctl.start = (state_reg == S_SQ_GO);

    pbc_isqrt u_isqrt (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (sq_ctl),
        .value(best_reg),
        .sts  (sq_sts),
        .root (sq_root)
    );

    always_comb
    begin
        state_next   = state_reg;
        sum_x_next   = sum_x_reg;
        sum_y_next   = sum_y_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        idx_next     = idx_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        dist_next    = dist_reg;
        best_next    = best_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        out_cx_next  = out_cx_reg;
        out_cy_next  = out_cy_reg;
        out_rad_next = out_rad_reg;
        out_ovf_next = out_ovf_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_accept)
                begin
                    if (store_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        sum_x_next = sum_x_reg + SUM_BITS'(vx_in);
                        sum_y_next = sum_y_reg + SUM_BITS'(vy_in);
                        cnt_next   = cnt_reg + 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        state_next = S_DIVX_GO;
                    end
                end
            end
            S_DIVX_GO:
            begin
                state_next = S_DIVX_WAIT;
            end
            S_DIVX_WAIT:
            begin
                if (div_sts.done)
                begin
                    cx_next    = div_q[COORD_BITS-1:0];
                    state_next = S_DIVY_WAIT;
                end
            end
            S_DIVY_WAIT:
            begin
                if (div_sts.done)
                begin
                    cy_next    = div_q[COORD_BITS-1:0];
                    idx_next   = '0;
                    best_next  = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_DX;
            end
            S_DX:
            begin
                dist_next  = prod;
                state_next = S_DY;
            end
            S_DY:
            begin
                dist_next  = dist_reg + prod;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (dist_reg > best_reg)
                begin
                    best_next = dist_reg;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == cnt_reg - 1'b1)
                begin
                    state_next = S_SQ_GO;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_SQ_GO:
            begin
                state_next = S_SQ_WAIT;
            end
            S_SQ_WAIT:
            begin
                if (sq_sts.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    out_cx_next  = cx_reg;
                    out_cy_next  = cy_reg;
                    out_rad_next = sq_root;
                    out_ovf_next = ovf_reg;
                    sum_x_next   = '0;
                    sum_y_next   = '0;
                    cnt_next     = '0;
                    ovf_next     = 1'b0;
                    state_next   = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sum_x_reg   <= sum_x_next;
            sum_y_reg   <= sum_y_next;
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        dist_reg    <= dist_next;
        best_reg    <= best_next;
        out_cx_reg  <= out_cx_next;
        out_cy_reg  <= out_cy_next;
        out_rad_reg <= out_rad_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'({out_rad_reg, out_cy_reg, out_cx_reg});
    assign m_axis_tuser  = out_ovf_reg;

    // a full store never takes another write
    `PBC_ASSERT_IMPL(a_full_no_write, store_full, !ram_we)
    // the pass only reads entries of the current polygon
    `PBC_ASSERT_IMPL(a_pass_in_range, state_reg == S_RD, idx_reg < cnt_reg && cnt_reg != '0)
    // the last vertex starts the centroid division
    `PBC_ASSERT_NEXT(a_last_starts, in_accept && s_axis_tlast, state_reg == S_DIVX_GO)
    // a pending result keeps the block from clearing its sums
    `PBC_ASSERT_NEXT(a_done_holds, state_reg == S_DONE && m_valid_reg && !m_axis_tready,
                     state_reg == S_DONE)

endmodule

[hw/rtl/pbc_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module pbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/pbc_div.sv]
// signed by unsigned restoring divider, one quotient bit per cycle
// depends on pbc_pkg
`timescale 1ns / 1ps

module pbc_div
    import pbc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  unit_ctl_t                  ctl,
    input  logic signed [SUM_BITS-1:0] dividend,
    input  logic [CNT_BITS-1:0]        divisor,
    output unit_sts_t                  sts,
    output logic signed [SUM_BITS-1:0] quotient
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [DIV_STEP_BITS-1:0] step_reg, step_next;
    logic                     neg_reg, neg_next;
    logic [SUM_BITS-1:0]      num_reg, num_next;
    logic [CNT_BITS-1:0]      rem_reg, rem_next;
    logic [CNT_BITS-1:0]      den_reg, den_next;
    logic [CNT_BITS:0]        trial;
    logic                     fits;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, num_reg[SUM_BITS-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = dividend[SUM_BITS-1];
            num_next  = dividend[SUM_BITS-1] ? $unsigned(-dividend) : $unsigned(dividend);
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? CNT_BITS'(trial - {1'b0, den_reg}) : CNT_BITS'(trial);
            num_next = {num_reg[SUM_BITS-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == DIV_STEP_BITS'(SUM_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient = neg_reg ? -$signed(num_reg) : $signed(num_reg);
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

[hw/rtl/pbc_isqrt.sv]
// floor integer square root, one root bit per cycle
// depends on pbc_pkg
`timescale 1ns / 1ps

module pbc_isqrt
    import pbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  unit_ctl_t            ctl,
    input  logic [DIST_BITS-1:0] value,
    output unit_sts_t            sts,
    output logic [ROOT_BITS-1:0] root
);

    localparam int REM_BITS = ROOT_BITS + 3;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [SQ_STEP_BITS-1:0] step_reg, step_next;
    logic [DIST_BITS-1:0]    val_reg, val_next;
    logic [REM_BITS-1:0]     rem_reg, rem_next;
    logic [ROOT_BITS-1:0]    root_reg, root_next;
    logic [REM_BITS-1:0]     rem_sh;
    logic [REM_BITS-1:0]     trial;
    logic                    fits;

    // bring down two bits, trial is 4*root + 1
    assign rem_sh = {rem_reg[REM_BITS-3:0], val_reg[DIST_BITS-1 -: 2]};
    assign trial  = REM_BITS'({root_reg, 2'b01});
    assign fits   = rem_sh >= trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? rem_sh - trial : rem_sh;
            root_next = {root_reg[ROOT_BITS-2:0], fits};
            val_next  = {val_reg[DIST_BITS-3:0], 2'b00};
            step_next = step_reg + 1'b1;
            if (step_reg == SQ_STEP_BITS'(ROOT_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root     = root_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule
